/* src/aes_pkg.sv */
// AES-128 package: S-box table, round constants, round functions and config codes.
// No dependencies.
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned AddrWidth = 4;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic [AddrWidth-1:0] {
        ADDR_KEY_HIGH = 4'h0,
        ADDR_KEY_LOW  = 4'h8
    } cfg_addr_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
            8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
            8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
            8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
            8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
            8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
            8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
            8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
            8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
            8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
            8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
            8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
            8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
            8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
            8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
            8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
            8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
            8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
            8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
            8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
            8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
            8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
            8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
            8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
            8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
            8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
            8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
            8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
            8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
            8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
            8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
            8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
            8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
            8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
            8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
            8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
            8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
            8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
            8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
            8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
            8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
            8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
            8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
            8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
            8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
            8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
            8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
            8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
            8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
            8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
            8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
            8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
            8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    // round constant for rounds 1..10
    function automatic byte_t rcon(input logic [3:0] rnd);
        byte_t r;
        case (rnd)
            4'd1: r = 8'h01;
            4'd2: r = 8'h02;
            4'd3: r = 8'h04;
            4'd4: r = 8'h08;
            4'd5: r = 8'h10;
            4'd6: r = 8'h20;
            4'd7: r = 8'h40;
            4'd8: r = 8'h80;
            4'd9: r = 8'h1B;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t get_byte(input block_t b, input int i);
        return b[127-8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows, optional MixColumns; round key added by caller
    function automatic block_t round_fn(input block_t s, input logic do_mix);
        block_t t;
        byte_t a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
            end
        end
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, 4*c);
                a1 = get_byte(t, 4*c+1);
                a2 = get_byte(t, 4*c+2);
                a3 = get_byte(t, 4*c+3);
                all = a0 ^ a1 ^ a2 ^ a3;
                t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
                t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        return t;
    endfunction

endpackage

/* src/aes_if.sv */
// Valid/ready channel interfaces for plaintext in and ciphertext out.
// Uses no package.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        end_of_message;
    modport source (output valid, block_high, block_low, end_of_message, input ready);
    modport sink   (input valid, block_high, block_low, end_of_message, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        last_out;
    modport source (output valid, cipher_high, cipher_low, last_out, input ready);
    modport sink   (input valid, cipher_high, cipher_low, last_out, output ready);
endinterface

/* src/aes128_block_encrypt.sv */
// AES-128 ECB encryptor, top level: key registers, APB port, ten-round pipeline.
// Depends on aes_pkg and the channel interfaces in aes_if.sv.
//
// Usage:
//  - Load the key over APB: key_high at 0x0, key_low at 0x8 (64-bit pwdata).
//    Write only while the pipeline holds no words. Both read back.
//  - Plaintext words enter on "din" (valid/ready), ciphertext words leave on
//    "dout" with the end-of-message flag copied through.
//  - Stage 0 adds the initial round key; stages 1..10 each do one AES round
//    and compute that round's key beside it, so the key travels with the word.
//  - Stage 0 loads at the accepting edge and stages 1..10 follow in order;
//    dout.valid comes from stage 10. Throughput: one word per cycle while dout
//    is not stalled, set by the one-round-per-stage pipeline.
//  - Stall: a stage advances only when it is empty or the stage after it does;
//    a bubble anywhere is squeezed out, so din.ready stays high while any stage
//    ahead of a stalled output is empty. Nothing is dropped or repeated.
//  - Reset clears the key registers and all stage valid bits.
module aes128_block_encrypt (
    input  logic                          clk,
    input  logic                          rst_n,
    aes_in_if.sink                        din,
    aes_out_if.source                     dout,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aes_pkg::AddrWidth-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import aes_pkg::*;

    localparam int unsigned Stages = NumRounds + 1;

    logic [63:0] key_high_reg, key_low_reg;

    // stage registers: 0 holds state after initial key add
    block_t            state_reg [Stages];
    block_t            rkey_reg  [Stages];
    logic              last_reg  [Stages];
    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] adv;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_KEY_HIGH: key_high_reg <= pwdata;
                ADDR_KEY_LOW:  key_low_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_KEY_HIGH: prdata = key_high_reg;
            ADDR_KEY_LOW:  prdata = key_low_reg;
            default:       prdata = '0;
        endcase
    end

    // stage i loads when it is empty or its content moves on
    always_comb begin
        adv[Stages-1] = !valid_reg[Stages-1] || dout.ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign din.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) valid_reg[0] <= din.valid;
            for (int i = 1; i < Stages; i++) begin
                if (adv[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv[0]) begin
            state_reg[0] <= {din.block_high, din.block_low} ^ {key_high_reg, key_low_reg};
            rkey_reg[0]  <= {key_high_reg, key_low_reg};
            last_reg[0]  <= din.end_of_message;
        end
        for (int i = 1; i < Stages; i++) begin
            if (adv[i]) begin
                state_reg[i] <= round_fn(state_reg[i-1], i != Stages - 1)
                                ^ next_key(rkey_reg[i-1], 4'(i));
                rkey_reg[i]  <= next_key(rkey_reg[i-1], 4'(i));
                last_reg[i]  <= last_reg[i-1];
            end
        end
    end

    assign dout.valid       = valid_reg[Stages-1];
    assign dout.cipher_high = state_reg[Stages-1][127:64];
    assign dout.cipher_low  = state_reg[Stages-1][63:0];
    assign dout.last_out    = last_reg[Stages-1];

    // a stalled output must stay valid and keep the high half of its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.ready |=> dout.valid && $stable(dout.cipher_high))
        else $error("output word changed under stall");

    // input is always ready when the output is ready
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        dout.ready |-> din.ready)
        else $error("pipeline stalled with free output");

    // an accepted word sits in stage 0 right after the accepting edge
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> valid_reg[0])
        else $error("accepted word lost at stage 0");

endmodule
